// ===== src/vfm_pkg.sv =====
// Shared types, tables and face evaluation for the voxel face mesher.
package vfm_pkg;

   typedef struct packed {
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic signed [15:0] pos_z;
      logic [26:0]        neighbour_solid;
   } req_type;

   typedef struct packed {
      logic signed [15:0] vert_x;
      logic signed [15:0] vert_y;
      logic signed [15:0] vert_z;
      logic [6:0]         vert_attr;
      logic               last_vertex;
   } rsp_type;

   localparam int NUM_FACES = 6;
   localparam int NUM_VERTS = 6;

   typedef struct packed {
      logic            vis;
      logic            flip;
      logic [3:0][1:0] ao;
   } face_type;

   // One classified voxel as it waits between front and back.
   typedef struct packed {
      logic signed [15:0]              pos_x;
      logic signed [15:0]              pos_y;
      logic signed [15:0]              pos_z;
      logic [NUM_FACES-1:0]            vis;
      logic [NUM_FACES-1:0]            flip;
      logic [NUM_FACES-1:0][3:0][1:0]  ao;
   } entry_type;

   // Faces go negative x, y, z, then positive x, y, z.
   localparam logic [1:0] FACE_AXIS [NUM_FACES] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2};
   localparam logic [1:0] NEXT_AXIS [3] = '{2'd1, 2'd2, 2'd0};
   localparam logic [1:0] PREV_AXIS [3] = '{2'd2, 2'd0, 2'd1};

   // Corner order for the split along 0-3 and along 1-2.
   localparam logic [1:0] ORDER_A [NUM_VERTS] = '{2'd0, 2'd1, 2'd3, 2'd0, 2'd3, 2'd2};
   localparam logic [1:0] ORDER_B [NUM_VERTS] = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd3, 2'd2};

   function automatic logic nb(input logic [26:0] m, input int ox, input int oy, input int oz);
      logic [4:0] idx;
      idx = 5'((oz + 1) * 9 + (oy + 1) * 3 + (ox + 1));
      return m[idx];
   endfunction

   function automatic face_type face_eval(input logic [26:0] m, input int f);
      int         ax;
      int         ua;
      int         wa;
      int         s;
      int         i;
      int         j;
      int         q [3];
      int         d1 [3];
      int         d2 [3];
      logic       s1;
      logic       s2;
      logic       cc;
      logic [2:0] cnt;
      logic [2:0] diag0;
      logic [2:0] diag1;
      face_type   r;
      ax = int'(FACE_AXIS[f]);
      ua = int'(NEXT_AXIS[ax]);
      wa = int'(PREV_AXIS[ax]);
      s  = (f >= 3) ? 1 : -1;
      for (int k = 0; k < 3; k++) begin
         q[k] = (k == ax) ? s : 0;
      end
      r.vis = !nb(m, q[0], q[1], q[2]);
      for (int c = 0; c < 4; c++) begin
         i = (c % 2 == 1) ? 1 : -1;
         j = (c >= 2) ? 1 : -1;
         for (int k = 0; k < 3; k++) begin
            d1[k] = q[k] + ((k == ua) ? i : 0);
            d2[k] = q[k] + ((k == wa) ? j : 0);
         end
         s1 = nb(m, d1[0], d1[1], d1[2]);
         s2 = nb(m, d2[0], d2[1], d2[2]);
         cc = nb(m, d1[0] + d2[0] - q[0], d1[1] + d2[1] - q[1], d1[2] + d2[2] - q[2]);
         cnt = {2'b00, s1} + {2'b00, s2} + {2'b00, cc};
         r.ao[c] = (s1 && s2) ? 2'd0 : 2'(3'd3 - cnt);
      end
      diag0  = {1'b0, r.ao[0]} + {1'b0, r.ao[3]};
      diag1  = {1'b0, r.ao[1]} + {1'b0, r.ao[2]};
      r.flip = diag0 > diag1;
      return r;
   endfunction

endpackage

// ===== src/vfm_front.sv =====
// Front end: takes voxel requests, works out face visibility and corner occlusion.
module vfm_front (
   input  logic                req_push,
   input  vfm_pkg::req_type    req_data,
   output logic                req_full,
   input  logic                q_full,
   output logic                q_push,
   output vfm_pkg::entry_type  q_entry
);

   vfm_pkg::face_type faces [vfm_pkg::NUM_FACES];

   always_comb begin
      for (int f = 0; f < vfm_pkg::NUM_FACES; f++) begin
         faces[f] = vfm_pkg::face_eval(req_data.neighbour_solid, f);
      end
   end

   always_comb begin
      q_entry.pos_x = req_data.pos_x;
      q_entry.pos_y = req_data.pos_y;
      q_entry.pos_z = req_data.pos_z;
      for (int f = 0; f < vfm_pkg::NUM_FACES; f++) begin
         q_entry.vis[f]  = faces[f].vis;
         q_entry.flip[f] = faces[f].flip;
         q_entry.ao[f]   = faces[f].ao;
      end
   end

   assign req_full = q_full;
   // fully hidden voxels are dropped here and never reach the back end
   assign q_push   = req_push && !q_full && (|q_entry.vis);

endmodule

// ===== src/vfm_fifo.sv =====
// Small queue of classified voxels between front and back.
module vfm_fifo #(
   parameter int DEPTH = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  vfm_pkg::entry_type  push_data,
   output logic                full,
   input  logic                pop,
   output vfm_pkg::entry_type  head,
   output logic                empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   vfm_pkg::entry_type slots_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full    = count_ff == CNT_W'(DEPTH);
   assign empty   = count_ff == '0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== src/vfm_back.sv =====
// Back end: walks the visible faces of the head voxel and emits six vertices per face.
module vfm_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_empty,
   input  vfm_pkg::entry_type  q_head,
   output logic                q_pop,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output vfm_pkg::rsp_type    rsp_data
);

   logic [vfm_pkg::NUM_FACES-1:0] rem_ff, rem_in;
   logic                          started_ff, started_in;
   logic [2:0]                    vtx_ff, vtx_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   vfm_pkg::rsp_type              rsp_data_ff, rsp_data_in;

   logic [vfm_pkg::NUM_FACES-1:0] cur_rem;
   logic [vfm_pkg::NUM_FACES-1:0] face_hot;
   logic [vfm_pkg::NUM_FACES-1:0] rest;
   logic [2:0]                    face_idx;
   logic [1:0]                    ax;
   logic [1:0]                    ua;
   logic [1:0]                    wa;
   logic                          positive;
   logic [1:0]                    corner;
   logic [1:0]                    pos_corner;
   logic [2:0]                    delta;
   logic                          can_emit;
   logic                          emit;
   logic                          face_done;
   logic                          last;

   assign cur_rem = started_ff ? rem_ff : q_head.vis;

   // lowest remaining visible face
   always_comb begin
      face_idx = '0;
      for (int f = vfm_pkg::NUM_FACES - 1; f >= 0; f--) begin
         if (cur_rem[f]) begin
            face_idx = 3'(f);
         end
      end
   end

   assign face_hot  = vfm_pkg::NUM_FACES'(1) << face_idx;
   assign rest      = cur_rem & ~face_hot;
   assign face_done = vtx_ff == 3'(vfm_pkg::NUM_VERTS - 1);
   assign last      = face_done && (rest == '0);

   assign ax       = vfm_pkg::FACE_AXIS[face_idx];
   assign ua       = vfm_pkg::NEXT_AXIS[ax];
   assign wa       = vfm_pkg::PREV_AXIS[ax];
   assign positive = face_idx >= 3'd3;
   assign corner   = q_head.flip[face_idx] ? vfm_pkg::ORDER_A[vtx_ff] : vfm_pkg::ORDER_B[vtx_ff];

   // negative faces trade the positions of corners 1 and 2, nothing else
   always_comb begin
      pos_corner = corner;
      if (!positive && (corner == 2'd1 || corner == 2'd2)) begin
         pos_corner = ~corner;
      end
      for (int a = 0; a < 3; a++) begin
         delta[a] = (2'(a) == ax && positive) || (2'(a) == ua && pos_corner[0])
                    || (2'(a) == wa && pos_corner[1]);
      end
   end

   assign can_emit = !rsp_valid_ff || rsp_pop;
   assign emit     = !q_empty && can_emit;
   assign q_pop    = emit && last;

   always_comb begin
      rem_in       = rem_ff;
      started_in   = started_ff;
      vtx_in       = vtx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_pop) begin
         rsp_valid_in = 1'b0;
      end
      if (emit) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.vert_x      = q_head.pos_x + 16'(delta[0]);
         rsp_data_in.vert_y      = q_head.pos_y + 16'(delta[1]);
         rsp_data_in.vert_z      = q_head.pos_z + 16'(delta[2]);
         rsp_data_in.vert_attr   = {q_head.ao[face_idx][corner], corner, positive, ax};
         rsp_data_in.last_vertex = last;
         if (face_done) begin
            vtx_in     = '0;
            rem_in     = rest;
            started_in = rest != '0;
         end else begin
            vtx_in     = vtx_ff + 3'd1;
            rem_in     = cur_rem;
            started_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff   <= 1'b0;
         vtx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         started_ff   <= started_in;
         vtx_ff       <= vtx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff      <= rem_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== src/voxel_face_mesher_ao.sv =====
// Top level of the voxel face mesher with per-vertex ambient occlusion.
//
// Request side: a voxel (position plus 3x3x3 solid mask) is taken at a clock edge with
// req_push high and req_full low. The front end classifies it in that same cycle and
// places it in a short queue (QUEUE_DEPTH voxels); fully hidden voxels are dropped.
// Result side: one vertex per cycle at most, shown on rsp_data while rsp_empty is low
// and taken with rsp_pop. Vertices come six per visible face, negative faces first,
// axis x, y, z; last_vertex marks the voxel's final vertex.
// The first vertex of a voxel goes from its queue slot into the output register, which
// drives rsp_data. The back end's vertex sequencer puts one vertex per cycle into the
// output register while it is empty or being popped. Requests keep flowing into the queue
// while the back end works, so a voxel may follow the previous one on the next clock.
// When the receiver stalls the output register holds its vertex, the back end stops,
// and req_full rises once the queue fills. Synchronous reset empties the queue and the
// output register; no clearing pass is needed.
module voxel_face_mesher_ao #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  vfm_pkg::req_type  req_data,
   output logic              req_full,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output vfm_pkg::rsp_type  rsp_data
);

   logic               q_full;
   logic               q_push;
   logic               q_pop;
   logic               q_empty;
   vfm_pkg::entry_type q_entry;
   vfm_pkg::entry_type q_head;

   vfm_front u_front (
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_entry  (q_entry)
   );

   vfm_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_entry),
      .full      (q_full),
      .pop       (q_pop),
      .head      (q_head),
      .empty     (q_empty)
   );

   vfm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== src/vfm_checker.sv =====
// Port-level checks for the voxel face mesher, bound to the top level.
module vfm_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_push,
   input vfm_pkg::req_type  req_data,
   input logic              req_full,
   input logic              rsp_empty,
   input logic              rsp_pop,
   input vfm_pkg::rsp_type  rsp_data
);

   // reset leaves both sides empty
   a_reset_clear: assert property (@(posedge clock) reset |=> rsp_empty && !req_full)
      else $error("block not empty after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_data))
      else $error("waiting vertex changed");

   // inside a voxel the next vertex follows without a gap
   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_pop && !rsp_empty && !rsp_data.last_vertex |=> !rsp_empty)
      else $error("gap inside a voxel's vertex run");

   // every triangulation ends on corner 2
   a_last_corner: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_data.last_vertex |-> rsp_data.vert_attr[4:3] == 2'd2)
      else $error("last vertex not on corner 2");

   a_axis_code: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> rsp_data.vert_attr[1:0] != 2'd3)
      else $error("invalid axis in vertex");

endmodule

bind voxel_face_mesher_ao vfm_checker u_vfm_checker (.*);

// ===== tb/voxel_face_mesher_ao_tb.sv =====
// Testbench for voxel_face_mesher_ao: predicts each voxel's mesh vertices and checks them in order.
`timescale 1ns / 100ps

module voxel_face_mesher_ao_tb;

   localparam int          WATCHDOG_LIMIT = 5000;
   localparam int          MAX_REPORTS    = 10;
   localparam int          RANDOM_VOXELS  = 300;
   localparam int          HOLD_CYCLES    = 400;
   localparam int          CENTRE_BIT     = 13;
   localparam logic [26:0] ALL_SOLID      = '1;
   // Mask bit of the neighbour across each face: -x, -y, -z, +x, +y, +z.
   localparam int          FACE_NEIGHBOUR [6] = '{12, 10, 4, 14, 16, 22};

   class vertex_checker;
      vfm_pkg::rsp_type pending_verts[$];
      int               errors;

      function bit solid(logic [26:0] m, int ox, int oy, int oz);
         return m[(oz + 1) * 9 + (oy + 1) * 3 + (ox + 1)];
      endfunction

      // Works out the vertices a voxel should produce and queues them.
      function void add_voxel(vfm_pkg::req_type r);
         int               n [3];
         int               u [3];
         int               w [3];
         int               off [4][3];
         int               ao [4];
         int               ord [6];
         int               p [3];
         int               s;
         int               i;
         int               j;
         int               s1;
         int               s2;
         int               cc;
         int               cr;
         int               count;
         vfm_pkg::rsp_type verts [36];
         p[0]  = int'(r.pos_x);
         p[1]  = int'(r.pos_y);
         p[2]  = int'(r.pos_z);
         count = 0;
         for (int si = 0; si < 2; si++) begin
            for (int ax = 0; ax < 3; ax++) begin
               s = (si == 0) ? -1 : 1;
               for (int k = 0; k < 3; k++) begin
                  n[k] = (k == ax) ? s : 0;
                  u[k] = (k == (ax + 1) % 3) ? 1 : 0;
                  w[k] = (k == (ax + 2) % 3) ? 1 : 0;
               end
               if (solid(r.neighbour_solid, n[0], n[1], n[2])) continue;
               // negative faces trade the positions of corners 1 and 2 only
               for (int k = 0; k < 3; k++) begin
                  off[0][k] = 0;
                  off[1][k] = (s > 0) ? u[k] : w[k];
                  off[2][k] = (s > 0) ? w[k] : u[k];
                  off[3][k] = u[k] + w[k];
                  if (s > 0) begin
                     for (int c = 0; c < 4; c++) off[c][k] += n[k];
                  end
               end
               for (int c = 0; c < 4; c++) begin
                  i  = (c % 2 == 1) ? 1 : -1;
                  j  = (c >= 2) ? 1 : -1;
                  s1 = solid(r.neighbour_solid, n[0] + i * u[0], n[1] + i * u[1],
                             n[2] + i * u[2]);
                  s2 = solid(r.neighbour_solid, n[0] + j * w[0], n[1] + j * w[1],
                             n[2] + j * w[2]);
                  cc = solid(r.neighbour_solid, n[0] + i * u[0] + j * w[0],
                             n[1] + i * u[1] + j * w[1], n[2] + i * u[2] + j * w[2]);
                  ao[c] = (s1 != 0 && s2 != 0) ? 0 : 3 - (s1 + s2 + cc);
               end
               if (ao[0] + ao[3] > ao[1] + ao[2]) ord = '{0, 1, 3, 0, 3, 2};
               else ord = '{0, 1, 2, 1, 3, 2};
               for (int k = 0; k < 6; k++) begin
                  cr = ord[k];
                  verts[count].vert_x      = 16'(p[0] + off[cr][0]);
                  verts[count].vert_y      = 16'(p[1] + off[cr][1]);
                  verts[count].vert_z      = 16'(p[2] + off[cr][2]);
                  verts[count].vert_attr   = {2'(ao[cr]), 2'(cr), 1'(s > 0), 2'(ax)};
                  verts[count].last_vertex = 1'b0;
                  count++;
               end
            end
         end
         if (count > 0) verts[count - 1].last_vertex = 1'b1;
         for (int k = 0; k < count; k++) pending_verts = {pending_verts, verts[k]};
      endfunction

      function void check_vertex(vfm_pkg::rsp_type got);
         vfm_pkg::rsp_type want;
         if (pending_verts.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("unexpected vertex: x=%0d y=%0d z=%0d attr=%h last=%b",
                        got.vert_x, got.vert_y, got.vert_z, got.vert_attr, got.last_vertex);
            return;
         end
         want = pending_verts.pop_front();
         if (got.vert_x !== want.vert_x || got.vert_y !== want.vert_y ||
             got.vert_z !== want.vert_z || got.vert_attr !== want.vert_attr ||
             got.last_vertex !== want.last_vertex) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("vertex error: exp x=%0d y=%0d z=%0d attr=%h last=%b, ",
                        want.vert_x, want.vert_y, want.vert_z, want.vert_attr,
                        want.last_vertex,
                        "got x=%0d y=%0d z=%0d attr=%h last=%b",
                        got.vert_x, got.vert_y, got.vert_z,
                        got.vert_attr, got.last_vertex);
         end
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             req_push;
   vfm_pkg::req_type req_data;
   logic             req_full;
   logic             rsp_empty;
   logic             rsp_pop;
   vfm_pkg::rsp_type rsp_data;
   vertex_checker    board;
   int               rsp_hold_cycles = 0;
   int               quiet_cycles = 0;

   voxel_face_mesher_ao uut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic vfm_pkg::req_type make_voxel(int x, int y, int z, logic [26:0] m);
      vfm_pkg::req_type r;
      r.pos_x           = 16'(x);
      r.pos_y           = 16'(y);
      r.pos_z           = 16'(z);
      r.neighbour_solid = m;
      return r;
   endfunction

   function automatic int random_coord();
      if ($urandom_range(0, 7) == 0) begin
         case ($urandom_range(0, 3))
            0: return -32768;
            1: return -32767;
            2: return 32765;
            default: return 32766;
         endcase
      end
      return int'($urandom_range(0, 65534)) - 32768;
   endfunction

   function automatic vfm_pkg::req_type random_voxel();
      logic [26:0] m;
      case ($urandom_range(0, 5))
         0: m = 27'($urandom);
         1: m = 27'($urandom & $urandom);
         2: m = 27'($urandom | $urandom);
         3: m = ALL_SOLID & ~(27'(1) << FACE_NEIGHBOUR[$urandom_range(0, 5)]);
         4: m = 27'($urandom & $urandom & $urandom);
         default: m = ($urandom_range(0, 3) == 0) ? ALL_SOLID : 27'($urandom | $urandom);
      endcase
      return make_voxel(random_coord(), random_coord(), random_coord(), m);
   endfunction

   // Leaves req_push high on return so the next request can follow on the next clock.
   task automatic push_voxel(input vfm_pkg::req_type r);
      req_push <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_full !== 1'b0);
      board.add_voxel(r);
   endtask

   task automatic idle_sender(input int cycles);
      req_push <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic wait_drained();
      idle_sender(1);
      while (board.pending_verts.size() != 0) @(posedge clock);
   endtask

   // Receiver: pop rate changes in phases; a requested hold-off overrides it.
   initial begin
      int pop_pct;
      int phase_left;
      pop_pct    = 100;
      phase_left = 0;
      rsp_pop    = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_pop <= 1'b0;
            rsp_hold_cycles--;
         end else begin
            if (phase_left == 0) begin
               case ($urandom_range(0, 3))
                  0: pop_pct = 100;
                  1: pop_pct = 75;
                  2: pop_pct = 40;
                  default: pop_pct = 8;
               endcase
               phase_left = $urandom_range(16, 96);
            end
            phase_left--;
            rsp_pop <= ($urandom_range(1, 100) <= pop_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) board.check_vertex(rsp_data);
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("voxel_face_mesher_ao: mismatch");
         $finish;
      end
   end

   initial begin
      vfm_pkg::req_type plan[$];
      int               sent;
      int               burst;
      board    = new();
      reset    <= 1'b1;
      req_push <= 1'b0;
      req_data <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      plan = {plan, make_voxel(0, 0, 0, 27'd0)};
      plan = {plan, make_voxel(-32768, -32768, -32768, 27'd0)};
      plan = {plan, make_voxel(32766, 32766, 32766, 27'd0)};          // top of the range, no wrap
      plan = {plan, make_voxel(-1, -1, -1, ALL_SOLID)};                // hidden
      plan = {plan, make_voxel(5, 6, 7, ALL_SOLID & ~(27'(1) << CENTRE_BIT))};
      plan = {plan, make_voxel(100, 200, 300, 27'(1) << CENTRE_BIT)};
      for (int f = 0; f < 6; f++)
         plan = {plan, make_voxel(32766 - f, -32768 + f, f * 1000,
                                  ALL_SOLID & ~(27'(1) << FACE_NEIGHBOUR[f]))};
      // dz=+1 layer solid except the -x,+y corner cell: +z face hidden
      plan = {plan, make_voxel(0, 0, 0, 27'h1BF << 18)};
      plan = {plan, make_voxel(1, 2, 3, 27'(1) << 18)};                // lone corner cell
      plan = {plan, make_voxel(1, 2, 3, 27'(1) << 20)};                // flips the split
      plan = {plan, make_voxel(-7, 8, -9, (27'(1) << 19) | (27'(1) << 21))};
      plan = {plan, make_voxel(32766, -32768, 0, 27'($urandom))};
      plan = {plan, make_voxel(-32768, 32766, 32766, 27'($urandom | $urandom))};
      foreach (plan[k]) push_voxel(plan[k]);
      wait_drained();

      // Long receiver hold-off while full-face voxels keep coming.
      rsp_hold_cycles = HOLD_CYCLES;
      repeat (12) push_voxel(make_voxel(random_coord(), random_coord(), random_coord(), 27'd0));

      sent = 0;
      while (sent < RANDOM_VOXELS) begin
         burst = $urandom_range(1, 12);
         repeat (burst) begin
            push_voxel(random_voxel());
            sent++;
         end
         if ($urandom_range(0, 2) != 0) idle_sender($urandom_range(1, 16));
      end

      wait_drained();
      repeat (20) @(posedge clock);
      if (board.errors == 0 && board.pending_verts.size() == 0)
         $display("voxel_face_mesher_ao: match");
      else
         $display("voxel_face_mesher_ao: mismatch");
      $finish;
   end

endmodule

// ===== sim.f =====
src/vfm_pkg.sv
src/vfm_front.sv
src/vfm_fifo.sv
src/vfm_back.sv
src/voxel_face_mesher_ao.sv
src/vfm_checker.sv
tb/voxel_face_mesher_ao_tb.sv
